[design/u2d_pkg.sv]
package u2d_pkg;

	// Widths of one BCD digit and of the ASCII result field
	localparam int unsigned DIGIT_W       = 4;
	localparam int unsigned CHAR_W        = 6;
	// Input bits folded into the BCD register per conversion cycle
	localparam int unsigned BITS_PER_STEP = 8;
	// Low six bits of the ASCII code for '0'
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FIND,
		ST_EMIT
	} u2d_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic find;
		logic emit_next;
	} u2d_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic conv_last;
		logic digit_last;
	} u2d_status_t;

endpackage

[design/u2d_in_if.sv]
interface u2d_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

[design/u2d_out_if.sv]
interface u2d_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] digit_char;
	logic       last_digit;

	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

[design/u2d_datapath.sv]
module u2d_datapath
	import u2d_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       number,
	input  u2d_cmd_t          cmd,
	output u2d_status_t       status,
	output logic [CHAR_W-1:0] digit_char
);

	localparam int unsigned STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int unsigned PAD_W  = STEPS * BITS_PER_STEP;
	// Decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
	localparam int unsigned NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BCD_W  = NDIG * DIGIT_W;
	localparam int unsigned IDX_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
	localparam int unsigned STEP_W = $clog2(STEPS + 1);

	logic [PAD_W-1:0]  val_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_cnt_q;
	logic [IDX_W-1:0]  idx_q;

	logic [PAD_W-1:0]  val_next;
	logic [BCD_W-1:0]  bcd_next;
	logic [IDX_W-1:0]  top_idx;
	logic [DIGIT_W-1:0] cur_digit;

	// Double dabble over BITS_PER_STEP input bits: adjust digits, then shift one bit in
	always_comb begin
		val_next = val_q;
		bcd_next = bcd_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (bcd_next[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					bcd_next[d*DIGIT_W +: DIGIT_W] = bcd_next[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			bcd_next = {bcd_next[BCD_W-2:0], val_next[PAD_W-1]};
			val_next = {val_next[PAD_W-2:0], 1'b0};
		end
	end

	// Locate the most significant nonzero digit; zero value starts at digit zero
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < NDIG; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
				top_idx = IDX_W'(d);
			end
		end
	end

	// Conversion and emission registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= PAD_W'(number[VALUE_WIDTH-1:0]);
			bcd_q <= '0;
		end else if (cmd.step) begin
			val_q <= val_next;
			bcd_q <= bcd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.load) begin
				step_cnt_q <= STEP_W'(STEPS);
			end else if (cmd.step) begin
				step_cnt_q <= step_cnt_q - STEP_W'(1);
			end
			if (cmd.find) begin
				idx_q <= top_idx;
			end else if (cmd.emit_next) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	assign cur_digit         = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
	assign digit_char        = ASCII_ZERO + CHAR_W'(cur_digit);
	assign status.conv_last  = (step_cnt_q == STEP_W'(1));
	assign status.digit_last = (idx_q == '0);

	// The leading digit of a run is nonzero unless the run is the single digit zero
	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find |=> (cur_digit != '0) || (idx_q == '0))
		else $error("leading digit is zero in a multi-digit run");

	// The first digit emitted after the leading-digit search is a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.find) |-> cur_digit <= DIGIT_W'(9))
		else $error("BCD digit out of range");

	// Stepping never runs past the programmed count
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> step_cnt_q != '0)
		else $error("conversion step with exhausted counter");

endmodule

[design/u2d_ctrl.sv]
module u2d_ctrl
	import u2d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  u2d_status_t status,
	output u2d_cmd_t    cmd
);

	u2d_state_t state_q;
	u2d_state_t state_next;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_CONV;
			end
			ST_CONV: begin
				if (status.conv_last) state_next = ST_FIND;
			end
			ST_FIND: begin
				state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready && status.digit_last) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.step = 1'b1;
			end
			ST_FIND: begin
				cmd.find = 1'b1;
			end
			ST_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit_next = out_ready && !status.digit_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Input and output sides are never open together
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output both active");

	// Final conversion step always leads into the digit search
	a_conv_to_find: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) && status.conv_last |=> state_q == ST_FIND)
		else $error("conversion did not hand over to search");

	// A stalled digit keeps the block emitting
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("emission dropped under stall");

endmodule

[design/unsigned_to_decimal_ascii_top.sv]
// Channel     Dir   Payload                               Handshake
// number_ch   in    number[63:0]                          valid/ready
// digit_ch    out   digit_char[5:0], last_digit           valid/ready
//
// An item is accepted in the idle state, goes through the double-dabble conversion steps and the
// leading-digit search, then emits one digit per cycle while digit_ch is ready.
// The shift-and-adjust unit folds 8 input bits into the BCD register per cycle.
// Reset clears the controller state and the counters; no clearing pass.
// A stall on digit_ch holds the current digit; number_ch is ready only when idle.
module unsigned_to_decimal_ascii_top
	import u2d_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input logic      clk,
	input logic      arst_n,
	u2d_in_if.sink   number_ch,
	u2d_out_if.source digit_ch
);

	u2d_cmd_t    cmd;
	u2d_status_t status;

	u2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number_ch.valid),
		.in_ready  (number_ch.ready),
		.out_valid (digit_ch.valid),
		.out_ready (digit_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	u2d_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.number     (number_ch.number),
		.cmd        (cmd),
		.status     (status),
		.digit_char (digit_ch.digit_char)
	);

	assign digit_ch.last_digit = status.digit_last;

endmodule
